>>> design/qhb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the quadtree height-map binning block.
// No dependencies.
package qhb_pkg;

	localparam int DEF_MAX_LEVELS = 6;
	localparam int DEF_COUNT_BITS = 16;

	localparam int COORD_BITS = 24;
	localparam int HALF_BITS  = 23;
	localparam int LEVEL_BITS = 3;
	localparam int QUERY_BITS = 12;
	localparam int SUM_W      = 40;
	localparam int CNT_OUT_W  = 16;
	localparam int CW         = COORD_BITS + 3;
	localparam int DIV_CW     = $clog2(SUM_W + 1);
	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 144;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_OUTSIDE  = 3'd1,
		ST_FULL     = 3'd2,
		ST_RD_EMPTY = 3'd3,
		ST_RD_OCC   = 3'd4
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROOT_CX  = 3'd0,
		CFG_ROOT_CZ  = 3'd1,
		CFG_ROOT_HW  = 3'd2,
		CFG_ROOT_HH  = 3'd3,
		CFG_LEVELS   = 3'd4
	} cfg_idx_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic clr;
		logic load;
		logic root;
		logic step;
		logic mrd;
		logic upd;
		logic dstart;
		logic fin;
	} qhb_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic lvl_done;
		logic drop;
		logic div_done;
		logic out_busy;
	} qhb_stat_t;

endpackage

>>> design/qhb_div.sv
`timescale 1ns / 1ps
// Serial restoring divider: signed sum over unsigned count, one bit a cycle.
// Depends on qhb_pkg.
module qhb_div import qhb_pkg::*; #(
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [SUM_W-1:0] dividend,
	input  logic [COUNT_BITS-1:0]   divisor,
	output logic signed [SUM_W-1:0] quotient,
	output logic                    done
);

	logic              busy_q, done_q, neg_q;
	logic [DIV_CW-1:0] step_q;
	logic [SUM_W-1:0]  quo_q, mag;
	logic [COUNT_BITS-1:0] rem_q, div_q;
	logic [COUNT_BITS:0]   trial, rem_n;
	logic              ge;

	always_comb begin
		mag   = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
		trial = {rem_q, quo_q[SUM_W-1]};
		ge    = trial >= {1'b0, div_q};
		rem_n = ge ? trial - {1'b0, div_q} : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_CW'(1);
				if (step_q == DIV_CW'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			neg_q <= dividend[SUM_W-1];
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], ge};
			rem_q <= rem_n[COUNT_BITS-1:0];
		end
	end

	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);
	assign done     = done_q;

endmodule

>>> design/qhb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences clear, descent, cell update, divide, output.
// Depends on qhb_pkg.
module qhb_ctrl import qhb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  logic      in_op,
	input  qhb_stat_t st,
	output qhb_cmd_t  cmd
);

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_ROOT  = 9'b000000100,
		S_DESC  = 9'b000001000,
		S_MRD   = 9'b000010000,
		S_UPD   = 9'b000100000,
		S_DST   = 9'b001000000,
		S_DWT   = 9'b010000000,
		S_FIN   = 9'b100000000
	} state_t;

	state_t state_q, state_n;

	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (st.clr_done) state_n = S_IDLE;
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_n  = (in_op == OP_READ) ? S_DESC : S_ROOT;
				end
			end
			S_ROOT: begin
				cmd.root = 1'b1;
				state_n  = S_DESC;
			end
			S_DESC: begin
				if (st.drop) state_n = S_FIN;
				else if (st.lvl_done) state_n = S_MRD;
				else cmd.step = 1'b1;
			end
			S_MRD: begin
				cmd.mrd = 1'b1;
				state_n = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_n = S_DST;
			end
			S_DST: begin
				cmd.dstart = 1'b1;
				state_n    = S_DWT;
			end
			S_DWT: begin
				if (st.div_done) state_n = S_FIN;
			end
			S_FIN: begin
				if (!st.out_busy) begin
					cmd.fin = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_n;
	end

endmodule

>>> design/qhb_dp.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, level descent, cell store, divider, output register.
// Depends on qhb_pkg and qhb_div.
module qhb_dp import qhb_pkg::*; #(
	parameter int MAX_LEVELS = DEF_MAX_LEVELS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_BITS-1:0]  cfg_data,
	input  logic [IN_DATA_W-1:0]   in_data,
	input  logic                   in_op,
	input  qhb_cmd_t               cmd,
	output qhb_stat_t              st,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_DATA_W-1:0]  out_data,
	output logic [2:0]             out_status
);

	localparam int IW    = 2 * MAX_LEVELS;
	localparam int CELLS = 1 << IW;
	localparam int LVW   = $clog2(MAX_LEVELS + 1);
	localparam int MW    = SUM_W + COUNT_BITS;

	logic signed [COORD_BITS-1:0] rcx_q, rcz_q;
	logic [HALF_BITS-1:0]         rhw_q, rhh_q;
	logic [LEVEL_BITS-1:0]        lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcx_q <= '0;
			rcz_q <= '0;
			rhw_q <= HALF_BITS'(65536);
			rhh_q <= HALF_BITS'(65536);
			lvl_q <= LEVEL_BITS'(6);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROOT_CX: rcx_q <= cfg_data;
				CFG_ROOT_CZ: rcz_q <= cfg_data;
				CFG_ROOT_HW: rhw_q <= cfg_data[HALF_BITS-1:0];
				CFG_ROOT_HH: rhh_q <= cfg_data[HALF_BITS-1:0];
				CFG_LEVELS:  lvl_q <= cfg_data[LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	logic [LVW-1:0] lv;
	always_comb begin
		if (int'(lvl_q) > MAX_LEVELS) lv = LVW'(MAX_LEVELS);
		else lv = LVW'(lvl_q);
	end

	// item registers
	logic                         op_q, drop_q, full_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic signed [CW-1:0]         cx_q, cz_q;
	logic [HALF_BITS-1:0]         hw_q, hh_q;
	logic [IW-1:0]                idx_q, path_q;
	logic [LVW-1:0]               lcnt_q;
	logic [IW:0]                  clr_q;
	logic [MW-1:0]                rd_q;
	logic signed [SUM_W-1:0]      sum_q;
	logic [COUNT_BITS-1:0]        cnt_q;

	// load decode
	logic [QUERY_BITS-1:0] qmask, query;
	logic [31:0]           q32;
	logic [IW-1:0]         idx_ld, path_ld;
	logic [5:0]            psh;
	always_comb begin
		query   = in_data[72 +: QUERY_BITS];
		qmask   = (QUERY_BITS'(1) << {lv, 1'b0}) - QUERY_BITS'(1);
		q32     = 32'(query & qmask);
		idx_ld  = (in_op == OP_READ) ? q32[IW-1:0] : '0;
		psh     = 6'(IW) - 6'({lv, 1'b0});
		path_ld = idx_ld << psh;
	end

	// descent
	logic [HALF_BITS-1:0]  hx, hz;
	logic signed [CW-1:0]  pxe, pze, hxe, hze, hx2, hz2, hwe, hhe;
	logic                  w_ok, e_ok, n_ok, s_ok, root_ok;
	logic [1:0]            qsel;
	logic signed [CW-1:0]  ncx, ncz;
	always_comb begin
		hx   = hw_q >> 1;
		hz   = hh_q >> 1;
		pxe  = CW'(px_q);
		pze  = CW'(pz_q);
		hxe  = $signed(CW'(hx));
		hze  = $signed(CW'(hz));
		hx2  = hxe <<< 1;
		hz2  = hze <<< 1;
		hwe  = $signed(CW'(hw_q));
		hhe  = $signed(CW'(hh_q));
		root_ok = (pxe >= cx_q - hwe) && (pxe < cx_q + hwe) &&
			(pze >= cz_q - hhe) && (pze < cz_q + hhe);
		w_ok = (pxe >= cx_q - hx2) && (pxe < cx_q);
		e_ok = (pxe >= cx_q) && (pxe < cx_q + hx2);
		n_ok = (pze >= cz_q) && (pze < cz_q + hz2);
		s_ok = (pze >= cz_q - hz2) && (pze < cz_q);
		if (op_q == OP_READ) qsel = path_q[IW-1 -: 2];
		else qsel = {!n_ok, !w_ok};
		ncx = qsel[0] ? cx_q + hxe : cx_q - hxe;
		ncz = qsel[1] ? cz_q - hze : cz_q + hze;
	end

	// cell update
	logic signed [SUM_W-1:0] rsum, nsum;
	logic [COUNT_BITS-1:0]   rcnt;
	logic                    full_now, ins, we;
	logic [IW-1:0]           waddr;
	logic [MW-1:0]           wdata;
	always_comb begin
		rsum     = $signed(rd_q[SUM_W-1:0]);
		rcnt     = rd_q[MW-1:SUM_W];
		full_now = rcnt == {COUNT_BITS{1'b1}};
		ins      = (op_q == OP_INSERT) && !full_now;
		nsum     = rsum + SUM_W'(py_q);
		we       = (cmd.clr && !clr_q[IW]) || (cmd.upd && ins);
		waddr    = cmd.clr ? clr_q[IW-1:0] : idx_q;
		wdata    = cmd.clr ? '0 : {rcnt + COUNT_BITS'(1), nsum};
	end

	logic [MW-1:0] mem [CELLS];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.mrd) rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clr && !clr_q[IW]) clr_q <= clr_q + (IW+1)'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
			lcnt_q <= '0;
		end else if (cmd.load) begin
			drop_q <= 1'b0;
			lcnt_q <= '0;
		end else if (cmd.root) begin
			if (!root_ok) drop_q <= 1'b1;
		end else if (cmd.step) begin
			lcnt_q <= lcnt_q + LVW'(1);
			if (op_q == OP_INSERT && !((w_ok || e_ok) && (n_ok || s_ok))) drop_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= in_op;
			px_q   <= $signed(in_data[0 +: COORD_BITS]);
			py_q   <= $signed(in_data[24 +: COORD_BITS]);
			pz_q   <= $signed(in_data[48 +: COORD_BITS]);
			cx_q   <= CW'(rcx_q);
			cz_q   <= CW'(rcz_q);
			hw_q   <= rhw_q;
			hh_q   <= rhh_q;
			idx_q  <= idx_ld;
			path_q <= path_ld;
		end else if (cmd.step) begin
			cx_q   <= ncx;
			cz_q   <= ncz;
			hw_q   <= hx;
			hh_q   <= hz;
			path_q <= path_q << 2;
			if (op_q == OP_INSERT) idx_q <= IW'({idx_q, qsel});
		end
		if (cmd.upd) begin
			sum_q  <= ins ? nsum : rsum;
			cnt_q  <= ins ? rcnt + COUNT_BITS'(1) : rcnt;
			full_q <= full_now;
		end
	end

	logic signed [SUM_W-1:0] quo;
	logic                    div_done;
	qhb_div #(.COUNT_BITS(COUNT_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.dstart),
		.dividend (sum_q),
		.divisor  (cnt_q),
		.quotient (quo),
		.done     (div_done)
	);

	// output register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q, data_n;
	status_t               status_q, status_n;
	logic [31:0]           c32, i32;
	logic [COORD_BITS-1:0] mean;
	always_comb begin
		c32  = 32'(cnt_q);
		i32  = 32'(idx_q);
		mean = (cnt_q != '0) ? quo[COORD_BITS-1:0] : '0;
		if (drop_q) begin
			status_n = ST_OUTSIDE;
			data_n   = '0;
		end else begin
			if (op_q == OP_READ) status_n = (cnt_q != '0) ? ST_RD_OCC : ST_RD_EMPTY;
			else status_n = full_q ? ST_FULL : ST_INSERTED;
			data_n = {4'b0, mean, c32[CNT_OUT_W-1:0], sum_q, cz_q[COORD_BITS-1:0],
				cx_q[COORD_BITS-1:0], i32[QUERY_BITS-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.fin) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_data_q <= data_n;
			status_q   <= status_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_data    = out_data_q;
	assign out_status  = status_q;
	assign st.clr_done = clr_q[IW];
	assign st.lvl_done = lcnt_q == lv;
	assign st.drop     = drop_q;
	assign st.div_done = div_done;
	assign st.out_busy = out_valid_q && !out_ready;

endmodule

>>> design/quadtree_heightmap_binning.sv
`timescale 1ns / 1ps
// Top level of the quadtree height-map binning block: controller plus datapath.
// Depends on qhb_pkg, qhb_ctrl, qhb_dp.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata point and query, s_tuser operation
//  m_*       out        m_tvalid/m_tready  m_tdata cell results, m_tuser status
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
// One item at a time. Time from one acceptance to the next is set mostly by the 40-step
// serial divider for the mean; a read skips the root check, a dropped point the cell update
// and the divider. After reset a clearing pass sweeps all 4^MAX_LEVELS cells of the store
// before the first item is taken. A result waits in the output register while the next item
// is accepted and descends; a stalled m_tready holds it.
module quadtree_heightmap_binning import qhb_pkg::*; #(
	parameter int MAX_LEVELS = DEF_MAX_LEVELS,
	parameter int COUNT_BITS = DEF_COUNT_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // point_x, point_y, point_z, query_cell
	input  logic [0:0]            s_tuser,   // operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // cell_index, center_x, center_z,
	                                         // height_sum, hit_count, mean_height
	output logic [2:0]            m_tuser,   // status
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data
);

	qhb_cmd_t  cmd;
	qhb_stat_t st;

	qhb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_op    (s_tuser[0]),
		.st       (st),
		.cmd      (cmd)
	);

	qhb_dp #(.MAX_LEVELS(MAX_LEVELS), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_data    (s_tdata),
		.in_op      (s_tuser[0]),
		.cmd        (cmd),
		.st         (st),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_status (m_tuser)
	);

	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == ST_OUTSIDE) |-> (m_tdata == '0))
		else $error("dropped point carries nonzero payload");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item accepted while one is in work");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !(m_tvalid && !m_tready))
		else $error("output register overwritten while stalled");

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for quadtree_heightmap_binning: stream driver, stream monitor
// and a cycle-free predictor of the cell store. Depends on qhb_pkg and the block RTL.
module tb_top;
	import qhb_pkg::*;

	localparam int CNT_BITS  = DEF_COUNT_BITS;
	localparam int CNT_LIMIT = (1 << CNT_BITS) - 1;
	localparam int LVL_MAX   = DEF_MAX_LEVELS;
	localparam int N_CELLS   = 1 << (2 * LVL_MAX);
	localparam int N_RAND    = 262;

	typedef struct {
		logic        op;
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic [11:0] q;
	} pt_item_t;

	typedef struct {
		status_t     st;
		logic [11:0] idx;
		logic [23:0] cx;
		logic [23:0] cz;
		logic [39:0] sum;
		logic [15:0] cnt;
		logic [23:0] mean;
	} bin_res_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [2:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [COORD_BITS-1:0] cfg_data = '0;

	logic [23:0] m_cx = 24'd0;
	logic [23:0] m_cz = 24'd0;
	logic [22:0] m_hw = 23'd65536;
	logic [22:0] m_hh = 23'd65536;
	logic [2:0]  m_lv = 3'd6;
	longint      cell_sum [N_CELLS];
	int          cell_cnt [N_CELLS];

	pt_item_t pending[$];
	bin_res_t bins_due[$];
	pt_item_t cur;
	int       errors = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       n_results = 0;
	int       hold_cnt = 0;
	bit       hold_done = 0;
	int       rdy_cyc = 0;

	quadtree_heightmap_binning #(
		.MAX_LEVELS(LVL_MAX),
		.COUNT_BITS(CNT_BITS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic bit in_box(longint px, longint pz, longint cx, longint cz,
	                              longint hw, longint hh);
		return px >= cx - hw && px < cx + hw && pz >= cz - hh && pz < cz + hh;
	endfunction

	function automatic bin_res_t bin_point(logic op, logic [23:0] x, logic [23:0] y,
	                                       logic [23:0] z, logic [11:0] q);
		bin_res_t r;
		longint   cx, cz, hw, hh, nx, nz, px, pz;
		int       lv;
		int       idx;
		int       qd;
		bit       found;
		bit       hit;
		cx = longint'($signed(m_cx));
		cz = longint'($signed(m_cz));
		hw = longint'(m_hw);
		hh = longint'(m_hh);
		lv = (m_lv > LVL_MAX) ? LVL_MAX : int'(m_lv);
		idx = 0;
		hit = 1;
		r.st = ST_OUTSIDE;
		if (op == OP_READ) begin
			idx = int'(q) & ((1 << (2 * lv)) - 1);
			for (int l = 0; l < lv; l++) begin
				qd = (idx >> (2 * (lv - 1 - l))) & 3;
				hw = hw >>> 1;
				hh = hh >>> 1;
				cx += qd[0] ? hw : -hw;
				cz += qd[1] ? -hh : hh;
			end
			r.st = (cell_cnt[idx] != 0) ? ST_RD_OCC : ST_RD_EMPTY;
		end else begin
			px = longint'($signed(x));
			pz = longint'($signed(z));
			hit = in_box(px, pz, cx, cz, hw, hh);
			for (int l = 0; l < lv && hit; l++) begin
				hw = hw >>> 1;
				hh = hh >>> 1;
				found = 0;
				for (int k = 0; k < 4 && !found; k++) begin
					nx = cx + (k[0] ? hw : -hw);
					nz = cz + (k[1] ? -hh : hh);
					if (in_box(px, pz, nx, nz, hw, hh)) begin
						found = 1;
						idx = (idx << 2) | k;
						cx = nx;
						cz = nz;
					end
				end
				hit = found;
			end
			if (hit) begin
				if (cell_cnt[idx] >= CNT_LIMIT) begin
					r.st = ST_FULL;
				end else begin
					cell_sum[idx] += longint'($signed(y));
					cell_cnt[idx]++;
					r.st = ST_INSERTED;
				end
			end
		end
		if (hit) begin
			r.idx = idx[11:0];
			r.cx = cx[23:0];
			r.cz = cz[23:0];
			r.sum = cell_sum[idx][39:0];
			r.cnt = cell_cnt[idx][15:0];
			r.mean = (cell_cnt[idx] != 0) ? 24'(cell_sum[idx] / longint'(cell_cnt[idx])) : '0;
		end else begin
			r.idx = '0;
			r.cx = '0;
			r.cz = '0;
			r.sum = '0;
			r.cnt = '0;
			r.mean = '0;
		end
		return r;
	endfunction

	// driver: bursts with random gaps, predict on each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				bins_due = {bins_due, bin_point(s_tuser[0], s_tdata[23:0], s_tdata[47:24],
				                                s_tdata[71:48], s_tdata[83:72])};
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					s_tdata <= {4'b0, cur.q, cur.z, cur.y, cur.x};
					s_tuser <= cur.op;
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction, stall on a rotating pattern plus one long hold
	always @(posedge clk or negedge arst_n) begin
		bin_res_t e;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results <= n_results + 1;
				if (bins_due.size() == 0) begin
					$error("unexpected result transaction");
					errors++;
				end else begin
					e = bins_due.pop_front();
					if (status_t'(m_tuser) !== e.st) begin
						$error("status exp %0d got %0d", e.st, m_tuser); errors++;
					end
					if (m_tdata[11:0] !== e.idx) begin
						$error("cell_index exp %0d got %0d", e.idx, m_tdata[11:0]); errors++;
					end
					if (m_tdata[35:12] !== e.cx) begin
						$error("center_x exp %h got %h", e.cx, m_tdata[35:12]); errors++;
					end
					if (m_tdata[59:36] !== e.cz) begin
						$error("center_z exp %h got %h", e.cz, m_tdata[59:36]); errors++;
					end
					if (m_tdata[99:60] !== e.sum) begin
						$error("height_sum exp %h got %h", e.sum, m_tdata[99:60]); errors++;
					end
					if (m_tdata[115:100] !== e.cnt) begin
						$error("hit_count exp %0d got %0d", e.cnt, m_tdata[115:100]); errors++;
					end
					if (m_tdata[139:116] !== e.mean) begin
						$error("mean_height exp %h got %h", e.mean, m_tdata[139:116]); errors++;
					end
				end
			end
			rdy_cyc <= rdy_cyc + 1;
			if (n_results == 300 && !hold_done) begin
				hold_done <= 1'b1;
				hold_cnt <= 800;
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else begin
				case ((rdy_cyc / 150) % 3)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					default: m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic add_ins(longint x, longint y, longint z);
		pt_item_t it;
		it.op = OP_INSERT;
		it.x = x[23:0];
		it.y = y[23:0];
		it.z = z[23:0];
		it.q = 12'($urandom);
		pending = {pending, it};
	endtask

	task automatic add_rd(int q);
		pt_item_t it;
		it.op = OP_READ;
		it.x = 24'($urandom);
		it.y = 24'($urandom);
		it.z = 24'($urandom);
		it.q = q[11:0];
		pending = {pending, it};
	endtask

	task automatic cfg_write(cfg_idx_t idx, longint val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[23:0];
		case (idx)
			CFG_ROOT_CX: m_cx = val[23:0];
			CFG_ROOT_CZ: m_cz = val[23:0];
			CFG_ROOT_HW: m_hw = val[22:0];
			CFG_ROOT_HH: m_hh = val[22:0];
			default:     m_lv = val[2:0];
		endcase
	endtask

	task automatic set_region(longint cx, longint cz, longint hw, longint hh, int lv);
		cfg_write(CFG_ROOT_CX, cx);
		cfg_write(CFG_ROOT_CZ, cz);
		cfg_write(CFG_ROOT_HW, hw);
		cfg_write(CFG_ROOT_HH, hh);
		cfg_write(CFG_LEVELS, lv);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic longint near_root(longint c, longint h);
		return c + longint'($urandom_range(0, 2 * h + 3)) - h - 2;
	endfunction

	// mostly inserts near the root, nearly half of them on three hot spots so some cells take repeated hits; plus reads
	task automatic add_random(int n);
		longint hx [3];
		longint hz [3];
		longint cx, cz, hw, hh;
		int     k;
		cx = longint'($signed(m_cx));
		cz = longint'($signed(m_cz));
		hw = longint'(m_hw);
		hh = longint'(m_hh);
		for (int i = 0; i < 3; i++) begin
			hx[i] = near_root(cx, hw);
			hz[i] = near_root(cz, hh);
		end
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 22)
				add_rd($urandom);
			else if (k < 30)
				add_ins($signed(24'($urandom)), $signed(24'($urandom)),
				        $signed(24'($urandom)));
			else if (k < 65)
				add_ins(hx[k % 3], $signed(24'($urandom)), hz[k % 3]);
			else
				add_ins(near_root(cx, hw), $signed(24'($urandom)), near_root(cz, hh));
		end
	endtask

	task automatic drain();
		wait (pending.size() == 0 && !s_tvalid && bins_due.size() == 0);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < N_CELLS; i++) begin
			cell_sum[i] = 0;
			cell_cnt[i] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// corners, edges, outside points, height extremes, reads
		add_ins(0, 0, 0);
		add_ins(-65536, 8388607, -65536);
		add_ins(65535, -8388608, 65535);
		add_ins(-65536, -1, 65535);
		add_ins(65535, 1, -65536);
		add_ins(65536, 5, 0);
		add_ins(0, 5, 65536);
		add_ins(-65537, 5, 0);
		add_ins(0, 5, -65537);
		add_ins(-8388608, 5, 8388607);
		add_ins(8388607, 5, -8388608);
		add_ins(0, -8388608, 0);
		add_ins(0, -3, 0);
		add_rd(0);
		add_rd(4095);
		add_rd(12'b010101010101);
		add_rd(12'b101010101010);
		add_random(N_RAND);
		drain();

		// sender paused above until all results arrived; now sweep the regions
		set_region(-8388608, 8388607, 8388607, 8388607, 7);
		add_rd(4095);
		add_ins(-8388608, 1, 8388607);
		add_random(N_RAND);
		drain();

		set_region(100, -300, 3, 5, 3);
		add_random(N_RAND);
		drain();

		set_region(1234, -5678, 1000, 777, 0);
		add_rd(4095);
		add_random(N_RAND);
		drain();

		set_region(8388607, -8388608, 1, 1, 1);
		add_ins(8388606, 2, -8388609);
		add_random(N_RAND);
		drain();

		set_region(-4000, 2500, 4096, 300, 2);
		add_random(N_RAND);
		drain();

		set_region(0, 0, 65536, 65536, 6);
		add_random(60);
		drain();

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
